>>> hdl/rfm_pkg.sv
// Shared types and constants for the first-match route filter.
`timescale 1ns / 1ps
`default_nettype none
package rfm_pkg;

  // Table selector codes
  localparam logic [1:0] TBL_IN    = 2'd0;
  localparam logic [1:0] TBL_OUT   = 2'd1;
  localparam logic [1:0] TBL_REDIS = 2'd2;
  localparam int unsigned TABLES   = 3;

  // Command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Rule word codes within a slot
  localparam logic [2:0] WRD_CTL    = 3'd0;
  localparam logic [2:0] WRD_IFX    = 3'd1;
  localparam logic [2:0] WRD_ID     = 3'd2;
  localparam logic [2:0] WRD_PFX_HI = 3'd3;
  localparam logic [2:0] WRD_PFX_LO = 3'd4;
  localparam logic [2:0] WRD_NB_HI  = 3'd5;
  localparam logic [2:0] WRD_NB_LO  = 3'd6;
  localparam int unsigned WORDS_USED = 7;

  // Slots reachable through the 7-bit word address
  localparam int unsigned MAX_SLOTS = 16;

  localparam logic [7:0] FULL_LEN = 8'd128;
  localparam logic [7:0] V4_LEN   = 8'd96;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  table_sel;
    logic [6:0]  rule_word_addr;
    logic [63:0] write_data;
    logic [63:0] router_id;
    logic [63:0] prefix_hi;
    logic [63:0] prefix_lo;
    logic [7:0]  plen;
    logic [63:0] neigh_hi;
    logic [63:0] neigh_lo;
    logic [31:0] ifindex;
    logic [7:0]  proto;
  } req_t;

  typedef struct packed {
    logic [15:0] metric;
    logic        matched;
    logic [3:0]  match_slot;
  } rsp_t;

  // One rule as read from the word memories
  typedef struct packed {
    logic [55:0] ctl;
    logic [31:0] ifx;
    logic [63:0] id;
    logic [63:0] pfx_hi;
    logic [63:0] pfx_lo;
    logic [63:0] nb_hi;
    logic [63:0] nb_lo;
  } rule_t;

endpackage
`default_nettype wire

>>> hdl/rfm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rfm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/rfm_match.sv
// Shared rule compare unit: checks one rule against the held lookup.
`timescale 1ns / 1ps
`default_nettype none
module rfm_match #(
  parameter int unsigned LocalProto = 255
) (
  input  wire rfm_pkg::rule_t rule_i,
  input  wire rfm_pkg::req_t  lk_i,
  output logic                hit_o
);

  logic [1:0]   af;
  logic [7:0]   rlen, ge, le, rproto, proto, nlen;
  logic         v4, has_id, has_nb;
  logic [127:0] mask, diff;

  always_comb begin
    af     = rule_i.ctl[2:1];
    rlen   = rule_i.ctl[15:8];
    ge     = rule_i.ctl[23:16];
    le     = rule_i.ctl[31:24];
    rproto = rule_i.ctl[39:32];
    proto  = (lk_i.table_sel == rfm_pkg::TBL_REDIS) ? lk_i.proto : 8'd0;
    has_id = lk_i.table_sel != rfm_pkg::TBL_REDIS;
    has_nb = lk_i.table_sel == rfm_pkg::TBL_IN;
    v4 = (lk_i.plen >= rfm_pkg::V4_LEN) && (lk_i.prefix_hi == 64'd0) &&
         (lk_i.prefix_lo[63:32] == 32'h0000_FFFF);
    // covering test over at most 128 bits
    nlen = (rlen > rfm_pkg::FULL_LEN) ? rfm_pkg::FULL_LEN : rlen;
    mask = ~({128{1'b1}} >> nlen);
    diff = {lk_i.prefix_hi ^ rule_i.pfx_hi, lk_i.prefix_lo ^ rule_i.pfx_lo};

    hit_o = 1'b1;
    if (af == 2'd1 && !v4) hit_o = 1'b0;
    if (af == 2'd2 && v4) hit_o = 1'b0;
    if (rule_i.ctl[3] && (!has_id || rule_i.id != lk_i.router_id)) hit_o = 1'b0;
    if (rule_i.ctl[4] && (lk_i.plen < rlen || (diff & mask) != 128'd0)) hit_o = 1'b0;
    if ((ge != 8'd0 || le < rfm_pkg::FULL_LEN) && (lk_i.plen > le || lk_i.plen < ge)) begin
      hit_o = 1'b0;
    end
    if (rule_i.ctl[5] && (!has_nb || rule_i.nb_hi != lk_i.neigh_hi ||
                          rule_i.nb_lo != lk_i.neigh_lo)) begin
      hit_o = 1'b0;
    end
    if (rule_i.ctl[6] && (rule_i.ifx == 32'd0 || lk_i.ifindex == 32'd0 ||
                          rule_i.ifx != lk_i.ifindex)) begin
      hit_o = 1'b0;
    end
    // protocol: a rule with no protocol rejects local routes
    if (rproto != 8'd0) begin
      if (proto == 8'd0 || rproto != proto) hit_o = 1'b0;
    end else if (proto == 8'(LocalProto)) begin
      hit_o = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/route_filter_first_match.sv
// Top level of the first-match route filter: word memories, valid bits, scan sequencer.
// Usage: pulse start with req_i while busy is low. A write (cmd 0) stores one rule
// word and its result (all zero) appears on rsp_o with done_o in the next cycle; busy
// stays low, so writes can go back to back. A lookup scans the selected table one rule
// per cycle through the single compare unit, reading all seven words of a rule at once
// from seven word memories. busy is high until the answer, and a lookup on table
// selector 3 answers the next cycle. done_o is a one-cycle strobe that cannot be held
// off, so the receiver must take rsp_o in that cycle. Valid flags reset to zero; rule
// words are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module route_filter_first_match #(
  parameter int unsigned RULES           = 16,
  parameter int unsigned LOCAL_PROTO     = 255,
  parameter int unsigned NO_ROUTE_METRIC = 65535
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rfm_pkg::req_t req_i,
  output logic               done_o,
  output rfm_pkg::rsp_t      rsp_o
);

  localparam int unsigned Slots = (RULES < rfm_pkg::MAX_SLOTS) ? RULES : rfm_pkg::MAX_SLOTS;
  localparam int unsigned Depth = rfm_pkg::TABLES * Slots;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned SW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [SW-1:0] LastSlot = SW'(Slots - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e         state_q, state_d;
  rfm_pkg::req_t  lk_q;
  logic [SW-1:0]  cnt_q, cnt_d, pslot_q;
  logic           iss_q, iss_d, pend_q, vbit_q;
  logic [Depth-1:0] valid_q;
  logic           done_d, done_q;
  rfm_pkg::rsp_t  rsp_d, rsp_q;
  logic           accept, wr_ok, hit;
  logic [AW-1:0]  waddr, raddr;
  logic [4:0]     wslot;
  logic [63:0]    rdw [rfm_pkg::WORDS_USED];
  rfm_pkg::rule_t rule;
  logic [15:0]    dflt;

  assign accept = start && !busy;
  assign busy   = (state_q == ST_SCAN);

  // Write address decode
  assign wslot = {1'b0, req_i.rule_word_addr[6:3]};
  assign wr_ok = accept && (req_i.cmd == rfm_pkg::CMD_WRITE) &&
                 (req_i.table_sel != 2'd3) && (wslot < 5'(Slots));
  assign waddr = AW'(req_i.table_sel) * AW'(Slots) + AW'(req_i.rule_word_addr[6:3]);
  assign raddr = AW'(lk_q.table_sel) * AW'(Slots) + AW'(cnt_q);

  // One memory per rule word, all read at the same slot
  for (genvar w = 0; w < rfm_pkg::WORDS_USED; w++) begin : g_word
    rfm_ram #(.Width(64), .Depth(Depth)) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_ok && (req_i.rule_word_addr[2:0] == 3'(w))),
      .waddr_i(waddr),
      .wdata_i(req_i.write_data),
      .re_i   (busy && iss_q),
      .raddr_i(raddr),
      .rdata_o(rdw[w])
    );
  end

  assign rule.ctl    = rdw[rfm_pkg::WRD_CTL][55:0];
  assign rule.ifx    = rdw[rfm_pkg::WRD_IFX][31:0];
  assign rule.id     = rdw[rfm_pkg::WRD_ID];
  assign rule.pfx_hi = rdw[rfm_pkg::WRD_PFX_HI];
  assign rule.pfx_lo = rdw[rfm_pkg::WRD_PFX_LO];
  assign rule.nb_hi  = rdw[rfm_pkg::WRD_NB_HI];
  assign rule.nb_lo  = rdw[rfm_pkg::WRD_NB_LO];

  rfm_match #(.LocalProto(LOCAL_PROTO)) u_match (
    .rule_i(rule),
    .lk_i  (lk_q),
    .hit_o (hit)
  );

  assign dflt = (lk_q.table_sel == rfm_pkg::TBL_REDIS) ? 16'(NO_ROUTE_METRIC) : 16'd0;

  // Sequencer: issue one slot per cycle, evaluate the slot read last cycle
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    iss_d   = iss_q;
    done_d  = 1'b0;
    rsp_d   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.cmd == rfm_pkg::CMD_LOOKUP && req_i.table_sel != 2'd3) begin
            state_d = ST_SCAN;
            cnt_d   = '0;
            iss_d   = 1'b1;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (iss_q) begin
          if (cnt_q == LastSlot) iss_d = 1'b0;
          else cnt_d = cnt_q + 1'b1;
        end
        if (pend_q && vbit_q && hit) begin
          done_d           = 1'b1;
          rsp_d.metric     = rule.ctl[55:40];
          rsp_d.matched    = 1'b1;
          rsp_d.match_slot = 4'(pslot_q);
          state_d          = ST_IDLE;
        end else if (pend_q && pslot_q == LastSlot) begin
          done_d       = 1'b1;
          rsp_d.metric = dflt;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      iss_q   <= 1'b0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      pend_q  <= busy && iss_q && (state_d == ST_SCAN);
      done_q  <= done_d;
      if (wr_ok && req_i.rule_word_addr[2:0] == rfm_pkg::WRD_CTL) begin
        valid_q[waddr] <= req_i.write_data[0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) lk_q <= req_i;
    pslot_q <= cnt_q;
    vbit_q  <= valid_q[raddr];
    rsp_q   <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

>>> hdl/rfm_checker.sv
// Port-level checker for the route filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rfm_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire rfm_pkg::req_t req_i,
  input wire logic          done_o,
  input wire rfm_pkg::rsp_t rsp_o
);

  // A write answers all zero in the next cycle
  a_write_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.cmd == rfm_pkg::CMD_WRITE |=>
      done_o && rsp_o.metric == 16'd0 && !rsp_o.matched && rsp_o.match_slot == 4'd0)
    else $error("write result wrong");

  // A lookup on a real table starts a scan
  a_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.cmd == rfm_pkg::CMD_LOOKUP && req_i.table_sel != 2'd3 |=> busy)
    else $error("lookup did not scan");

  // Scan ends exactly when the answer is shown
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("scan ended without result");

  // No result while a scan is under way
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && $past(busy) |-> !done_o)
    else $error("result during scan");

  // Unmatched results carry slot zero
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.matched |-> rsp_o.match_slot == 4'd0)
    else $error("slot without match");

endmodule

bind route_filter_first_match rfm_checker u_rfm_checker (.*);
`default_nettype wire
